@@ rtl/core/ppq_pkg.sv @@
// ----------------------------------------------------------------------------
// ppq_pkg: shared constants and types for the two-pool task queue
// Pool and FIFO sizes, derived widths, opcodes and the slot pick struct.
// ----------------------------------------------------------------------------
package ppq_pkg;

    localparam int SLOTS_PER_POOL = 16;
    localparam int OVERFLOW_DEPTH = 16;
    localparam int TASK_ID_BITS   = 16;

    // width of the identifier port, and the bits that are actually kept
    localparam int ID_PORT_W = 16;
    localparam int ID_W      = (TASK_ID_BITS < ID_PORT_W) ? TASK_ID_BITS : ID_PORT_W;

    localparam int SLOT_W         = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int SLOT_MEM_DEPTH = 2 << SLOT_W;

    localparam int PTR_W = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(OVERFLOW_DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } pick_t;

endpackage

@@ rtl/core/ping_pong_task_pool_queue.sv @@
// ----------------------------------------------------------------------------
// ping_pong_task_pool_queue: two slot pools plus an overflow FIFO
// Inserts go to the lowest free slot of the selected pool or the FIFO; pops
// take the lowest occupied slot of the current pool, the other pool, or the
// FIFO head.
//
//   channel  | dir | tdata            | tuser (low bit up)
//   ---------+-----+------------------+--------------------------------------
//   s_axis   | in  | task_id[15:0]    | opcode, progressed
//   m_axis   | out | out_task_id[15:0]| task_found, went_to_overflow,
//            |     |                  | insert_dropped
//
// For each request, the accept cycle runs the slot search and issues the
// memory access, the next cycle picks up the registered read data.
// A new request is accepted only after the last has left its response cycle.
// An output stall holds the block in its response cycle; the result register
// holds one finished result while the next request is already accepted.
// Reset clears valid bits, pointers, count and pool bit; memories need none.
// ----------------------------------------------------------------------------
module ping_pong_task_pool_queue
    import ppq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // task_id
    input  logic [1:0]  s_axis_tuser,   // opcode, progressed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_task_id
    output logic [2:0]  m_axis_tuser    // task_found, went_to_overflow, insert_dropped
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg, state_next;

    logic [1:0][SLOTS_PER_POOL-1:0] slot_valid_reg, slot_valid_next;
    logic                           cur_pool_reg, cur_pool_next;
    logic [PTR_W-1:0]               head_reg, head_next;
    logic [PTR_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]               fifo_cnt_reg, fifo_cnt_next;

    logic pend_found_reg, pend_found_next;
    logic pend_fifo_reg, pend_fifo_next;
    logic pend_ovf_reg, pend_ovf_next;
    logic pend_drop_reg, pend_drop_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [2:0]  out_flags_reg, out_flags_next;

    // memories
    logic [ID_W-1:0] slot_mem [0:SLOT_MEM_DEPTH-1];
    logic [ID_W-1:0] fifo_mem [0:OVERFLOW_DEPTH-1];
    logic [ID_W-1:0] slot_rdata_reg;
    logic [ID_W-1:0] fifo_rdata_reg;

    logic            slot_we, slot_re;
    logic [SLOT_W:0] slot_addr;
    logic            fifo_we, fifo_re;

    logic            accept;
    logic            is_pop;
    logic            ins_pool;
    logic [ID_W-1:0] tid;
    logic            load_out;
    logic [ID_W-1:0] pend_id;

    pick_t pick_free, pick_cur, pick_oth;

    ppq_pick u_pick_free
    (
        .mask (~slot_valid_reg[ins_pool]),
        .pick (pick_free)
    );

    ppq_pick u_pick_cur
    (
        .mask (slot_valid_reg[cur_pool_reg]),
        .pick (pick_cur)
    );

    ppq_pick u_pick_oth
    (
        .mask (slot_valid_reg[~cur_pool_reg]),
        .pick (pick_oth)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (s_axis_tuser[0] == OP_POP);
    assign ins_pool      = s_axis_tuser[1] ^ cur_pool_reg;
    assign tid           = s_axis_tdata[ID_W-1:0];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        begin
            r = (p == PTR_W'(OVERFLOW_DEPTH - 1)) ? '0 : p + 1'b1;
            return r;
        end
    endfunction

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        cur_pool_next   = cur_pool_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fifo_cnt_next   = fifo_cnt_reg;
        pend_found_next = pend_found_reg;
        pend_fifo_next  = pend_fifo_reg;
        pend_ovf_next   = pend_ovf_reg;
        pend_drop_next  = pend_drop_reg;
        slot_we         = 1'b0;
        slot_re         = 1'b0;
        slot_addr       = {ins_pool, pick_free.idx};
        fifo_we         = 1'b0;
        fifo_re         = 1'b0;

        if (accept)
        begin
            pend_found_next = 1'b0;
            pend_fifo_next  = 1'b0;
            pend_ovf_next   = 1'b0;
            pend_drop_next  = 1'b0;
            if (!is_pop)
            begin
                if (pick_free.hit)
                begin
                    slot_we = 1'b1;
                    slot_valid_next[ins_pool][pick_free.idx] = 1'b1;
                end
                else if (fifo_cnt_reg < CNT_W'(OVERFLOW_DEPTH))
                begin
                    fifo_we       = 1'b1;
                    tail_next     = wrap_inc(tail_reg);
                    fifo_cnt_next = fifo_cnt_reg + 1'b1;
                    pend_ovf_next = 1'b1;
                end
                else
                begin
                    pend_drop_next = 1'b1;
                end
            end
            else if (pick_cur.hit)
            begin
                slot_re         = 1'b1;
                slot_addr       = {cur_pool_reg, pick_cur.idx};
                pend_found_next = 1'b1;
                slot_valid_next[cur_pool_reg][pick_cur.idx] = 1'b0;
            end
            else
            begin
                // current pool empty: switch pools, then fall back to the FIFO
                cur_pool_next = ~cur_pool_reg;
                if (pick_oth.hit)
                begin
                    slot_re         = 1'b1;
                    slot_addr       = {~cur_pool_reg, pick_oth.idx};
                    pend_found_next = 1'b1;
                    slot_valid_next[~cur_pool_reg][pick_oth.idx] = 1'b0;
                end
                else if (fifo_cnt_reg != '0)
                begin
                    fifo_re         = 1'b1;
                    head_next       = wrap_inc(head_reg);
                    fifo_cnt_next   = fifo_cnt_reg - 1'b1;
                    pend_found_next = 1'b1;
                    pend_fifo_next  = 1'b1;
                end
            end
        end
    end

    // response cycle: move the finished result into the output register
    assign load_out = (state_reg == S_RESP) && (!out_valid_reg || m_axis_tready);
    assign pend_id  = pend_fifo_reg ? fifo_rdata_reg : slot_rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flags_next = out_flags_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = pend_found_reg ? 16'(pend_id) : '0;
                    out_flags_next = {pend_drop_reg, pend_ovf_reg, pend_found_reg};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            cur_pool_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fifo_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            cur_pool_reg   <= cur_pool_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fifo_cnt_reg   <= fifo_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_found_reg <= pend_found_next;
        pend_fifo_reg  <= pend_fifo_next;
        pend_ovf_reg   <= pend_ovf_next;
        pend_drop_reg  <= pend_drop_next;
        out_data_reg   <= out_data_next;
        out_flags_reg  <= out_flags_next;
    end

    // slot memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_addr] <= tid;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_addr];
        end
    end

    // overflow FIFO memory
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= tid;
        end
        if (fifo_re)
        begin
            fifo_rdata_reg <= fifo_mem[head_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

@@ rtl/core/ppq_pick.sv @@
// ----------------------------------------------------------------------------
// ppq_pick: lowest-set-bit priority encoder over one pool mask
// Reports whether any bit is set and the index of the lowest one.
// ----------------------------------------------------------------------------
module ppq_pick
    import ppq_pkg::*;
(
    input  logic [SLOTS_PER_POOL-1:0] mask,
    output pick_t                     pick
);

    always_comb
    begin
        pick.hit = |mask;
        pick.idx = '0;
        // scan from the top so the lowest set bit wins
        for (int i = SLOTS_PER_POOL - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                pick.idx = SLOT_W'(i);
            end
        end
    end

endmodule

@@ rtl/core/ppq_checker.sv @@
// ----------------------------------------------------------------------------
// ppq_checker: port-level checks for the two-pool task queue
// Watches both stream sides of the top level; attached by bind.
// ----------------------------------------------------------------------------
module ppq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a result that is not taken stays up
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // at most one of found, overflow and dropped per result
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("conflicting result flags");

    // nothing found means a zero identifier
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("identifier without a found task");

    // one request in flight: the cycle after an accept takes no request
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted during response cycle");

endmodule

bind ping_pong_task_pool_queue ppq_checker u_ppq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
